[src/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operand and result payload structs, datapath widths and function codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;   // magnitude product
  localparam int MAG_W         = PROD_W;              // sum of two products fits
  localparam int SHIFT_W       = $clog2(MAG_W);
  localparam int NUM_OUT_W     = MAG_W + 1;
  localparam int DEN_OUT_W     = MAG_W;

  localparam logic [MAG_W-1:0] MIN_DIVISOR = MAG_W'(2);

  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_MUL = 4'd2;
  localparam logic [3:0] FN_DIV = 4'd3;
  localparam logic [3:0] FN_LT  = 4'd4;
  localparam logic [3:0] FN_GT  = 4'd5;
  localparam logic [3:0] FN_LE  = 4'd6;
  localparam logic [3:0] FN_GE  = 4'd7;
  localparam logic [3:0] FN_EQ  = 4'd8;
  localparam logic [3:0] FN_NE  = 4'd9;

  typedef struct packed {
    logic        [3:0]               func;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [NUM_OUT_W-1:0] res_num;
    logic signed [DEN_OUT_W-1:0] res_den;
    logic                        truth;
    logic                        den_zero;
  } out_t;

endpackage

[src/rau_mul.sv]
// ----------------------------------------------------------------------------
// rau_mul: registered magnitude multiplier
// One unsigned operand-width product per cycle, result in the following cycle.
// ----------------------------------------------------------------------------
module rau_mul (
  input  logic                              clk,
  input  logic [rau_pkg::OPERAND_WIDTH-1:0] a,
  input  logic [rau_pkg::OPERAND_WIDTH-1:0] b,
  output logic [rau_pkg::PROD_W-1:0]        p
);

  logic [rau_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

[src/rau_gcd.sv]
// ----------------------------------------------------------------------------
// rau_gcd: binary gcd engine
// One shift or one subtract per cycle; common factors of two counted in k.
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rau_pkg::MAG_W-1:0]  x,
  input  logic [rau_pkg::MAG_W-1:0]  y,
  output logic                       done,
  output logic [rau_pkg::MAG_W-1:0]  g
);

  logic                         run_r;
  logic                         done_r;
  logic [rau_pkg::MAG_W-1:0]    x_r;
  logic [rau_pkg::MAG_W-1:0]    y_r;
  logic [rau_pkg::MAG_W-1:0]    g_r;
  logic [rau_pkg::SHIFT_W-1:0]  k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (x_r == '0 || y_r == '0)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
      k_r <= '0;
    end else if (run_r) begin
      if (x_r == '0 || y_r == '0) begin
        g_r <= (x_r | y_r) << k_r;
      end else if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= x_r - y_r;
      end else begin
        y_r <= y_r - x_r;
      end
    end
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

[src/rau_div.sv]
// ----------------------------------------------------------------------------
// rau_div: two-lane restoring divider
// Divides two dividends by one shared divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rau_pkg::MAG_W-1:0]  divisor,
  input  logic [rau_pkg::MAG_W-1:0]  n0,
  input  logic [rau_pkg::MAG_W-1:0]  n1,
  output logic                       done,
  output logic [rau_pkg::MAG_W-1:0]  q0,
  output logic [rau_pkg::MAG_W-1:0]  q1
);

  localparam int W = rau_pkg::MAG_W;

  logic                         run_r;
  logic                         done_r;
  logic [rau_pkg::SHIFT_W-1:0]  cnt_r;
  logic [W-1:0]                 d_r;
  logic [W-1:0]                 rem0_r;
  logic [W-1:0]                 rem1_r;
  logic [W-1:0]                 q0_r;
  logic [W-1:0]                 q1_r;
  logic [W:0]                   trial0;
  logic [W:0]                   trial1;
  logic                         fit0;
  logic                         fit1;
  logic                         last;

  assign trial0 = {rem0_r, q0_r[W-1]};
  assign trial1 = {rem1_r, q1_r[W-1]};
  assign fit0   = trial0 >= {1'b0, d_r};
  assign fit1   = trial1 >= {1'b0, d_r};
  assign last   = cnt_r == rau_pkg::SHIFT_W'(W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= divisor;
      q0_r   <= n0;
      q1_r   <= n1;
      rem0_r <= '0;
      rem1_r <= '0;
    end else if (run_r) begin
      rem0_r <= fit0 ? W'(trial0 - {1'b0, d_r}) : trial0[W-1:0];
      rem1_r <= fit1 ? W'(trial1 - {1'b0, d_r}) : trial1[W-1:0];
      q0_r   <= {q0_r[W-2:0], fit0};
      q1_r   <= {q1_r[W-2:0], fit1};
    end
  end

  assign done = done_r;
  assign q0   = q0_r;
  assign q1   = q1_r;

endmodule

[src/rational_arith_reduce_unit.sv]
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit: rational add/sub/mul/div/compare with reduction
// Cross-multiplies two signed fractions, reduces by the gcd of the result
// magnitudes and, for compares, tests the sign of the reduced difference.
// ----------------------------------------------------------------------------
//  channel  | ports                    | transfer
//  ---------+--------------------------+-------------------------------------
//  input    | start, busy, in_data     | edge with start high and busy low
//  result   | out_valid, out_data      | edge ending the one-cycle strobe
//
//  Steps: 3 products on one shared multiplier, 1 add, 1 load, the binary
//  gcd (one shift or subtract per cycle), the divider when the gcd is 2 or
//  more, and 1 output step before the strobe. Unused codes go from idle
//  straight to the output step.
//  busy is high from the transfer until the result strobe; reset (rst_n,
//  synchronous) returns to idle with no strobe. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_arith_reduce_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  rau_pkg::in_t   in_data,
  output logic           busy,
  output logic           out_valid,
  output rau_pkg::out_t  out_data
);

  localparam int OW = rau_pkg::OPERAND_WIDTH;
  localparam int PW = rau_pkg::PROD_W;
  localparam int MW = rau_pkg::MAG_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL0  = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_SUM   = 4'd4;
  localparam logic [3:0] ST_GLOAD = 4'd5;
  localparam logic [3:0] ST_GCD   = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  function automatic logic [OW-1:0] mag_of(input logic [OW-1:0] v);
    mag_of = v[OW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [3:0]           state_r;
  logic [3:0]           state_nxt;
  rau_pkg::in_t         in_r;
  logic [PW-1:0]        p0_r;
  logic [PW-1:0]        p1_r;
  logic [MW-1:0]        num_mag_r;
  logic [MW-1:0]        den_mag_r;
  logic                 num_neg_r;
  logic                 den_neg_r;
  logic                 out_valid_r;
  rau_pkg::out_t        out_data_r;

  // operand magnitudes and signs
  logic [OW-1:0]        an_m, ad_m, bn_m, bd_m;
  logic                 an_s, ad_s, bn_s, bd_s;
  logic                 is_mul, is_div;
  logic                 sign0, sign1, sign2;

  logic [OW-1:0]        mul_a;
  logic [OW-1:0]        mul_b;
  logic [PW-1:0]        mul_p;

  logic                 s0, s1;
  logic [MW-1:0]        sum_mag;
  logic                 sum_neg;

  logic                 gcd_start;
  logic                 gcd_done;
  logic [MW-1:0]        gcd_g;
  logic                 div_start;
  logic                 div_done;
  logic [MW-1:0]        div_q0;
  logic [MW-1:0]        div_q1;

  logic                 num_nz, den_nz;
  logic                 unordered, lt_w, gt_w, eq_w;
  logic [rau_pkg::NUM_OUT_W-1:0] num_ext;
  rau_pkg::out_t        res_w;

  assign an_m   = mag_of(in_r.a_num);
  assign ad_m   = mag_of(in_r.a_den);
  assign bn_m   = mag_of(in_r.b_num);
  assign bd_m   = mag_of(in_r.b_den);
  assign an_s   = in_r.a_num[OW-1];
  assign ad_s   = in_r.a_den[OW-1];
  assign bn_s   = in_r.b_num[OW-1];
  assign bd_s   = in_r.b_den[OW-1];
  assign is_mul = in_r.func == rau_pkg::FN_MUL;
  assign is_div = in_r.func == rau_pkg::FN_DIV;

  // product 0: numerator term, product 1: b_num*a_den cross term,
  // product 2: denominator
  assign sign0 = an_s ^ (is_mul ? bn_s : bd_s);
  assign sign1 = bn_s ^ ad_s;
  assign sign2 = ad_s ^ (is_div ? bn_s : bd_s);

  always_comb begin
    unique case (state_r)
      ST_MUL1: begin
        mul_a = bn_m;
        mul_b = ad_m;
      end
      ST_MUL2: begin
        mul_a = ad_m;
        mul_b = is_div ? bn_m : bd_m;
      end
      default: begin
        mul_a = an_m;
        mul_b = is_mul ? bn_m : bd_m;
      end
    endcase
  end

  rau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sign-magnitude add of the two cross products (mul and div pass product 0
  // through); sub and compares negate the second term
  always_comb begin
    s0 = (p0_r != '0) && sign0;
    s1 = (p1_r != '0) && (sign1 ^ (in_r.func != rau_pkg::FN_ADD));
    if (is_mul || is_div) begin
      sum_mag = p0_r;
      sum_neg = s0;
    end else if (s0 == s1) begin
      sum_mag = p0_r + p1_r;
      sum_neg = s0;
    end else if (p0_r >= p1_r) begin
      sum_mag = p0_r - p1_r;
      sum_neg = s0;
    end else begin
      sum_mag = p1_r - p0_r;
      sum_neg = s1;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  assign gcd_start = state_r == ST_GLOAD;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .x     (num_mag_r),
    .y     (den_mag_r),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  assign div_start = (state_r == ST_GCD) && gcd_done && (gcd_g >= rau_pkg::MIN_DIVISOR);

  rau_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (gcd_g),
    .n0      (num_mag_r),
    .n1      (den_mag_r),
    .done    (div_done),
    .q0      (div_q0),
    .q1      (div_q1)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.func > rau_pkg::FN_NE) ? ST_OUT : ST_MUL0;
        end
      end
      ST_MUL0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_GLOAD;
      ST_GLOAD: state_nxt = ST_GCD;
      ST_GCD: begin
        if (gcd_done) begin
          state_nxt = div_start ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == ST_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      in_r <= in_data;
    end
    if (state_r == ST_MUL1) begin
      p0_r <= mul_p;
    end
    if (state_r == ST_MUL2) begin
      p1_r <= mul_p;
    end
    if (state_r == ST_SUM) begin
      num_mag_r <= sum_mag;
      num_neg_r <= sum_neg;
      den_mag_r <= mul_p;
      den_neg_r <= (mul_p != '0) && sign2;
    end
    if (state_r == ST_DIV && div_done) begin
      num_mag_r <= div_q0;
      den_mag_r <= div_q1;
    end
    if (state_r == ST_OUT) begin
      out_data_r <= res_w;
    end
  end

  // result formatting and sign test; a zero denominator reads as a signed
  // infinity, zero over zero is unordered
  assign num_nz    = num_mag_r != '0;
  assign den_nz    = den_mag_r != '0;
  assign unordered = !num_nz && !den_nz;
  assign lt_w      = num_nz && (den_nz ? (num_neg_r != den_neg_r) : num_neg_r);
  assign gt_w      = num_nz && (den_nz ? (num_neg_r == den_neg_r) : !num_neg_r);
  assign eq_w      = !num_nz && den_nz;
  assign num_ext   = {1'b0, num_mag_r};

  always_comb begin
    res_w.res_num  = $signed(num_neg_r ? (~num_ext + 1'b1) : num_ext);
    res_w.res_den  = $signed(den_neg_r ? (~den_mag_r + 1'b1) : den_mag_r);
    res_w.den_zero = !den_nz;
    res_w.truth    = 1'b0;
    unique case (in_r.func) inside
      rau_pkg::FN_ADD,
      rau_pkg::FN_SUB,
      rau_pkg::FN_MUL,
      rau_pkg::FN_DIV: res_w.truth = 1'b0;
      rau_pkg::FN_LT:  res_w.truth = lt_w;
      rau_pkg::FN_GT:  res_w.truth = gt_w;
      rau_pkg::FN_LE:  res_w.truth = lt_w || eq_w;
      rau_pkg::FN_GE:  res_w.truth = gt_w || eq_w;
      rau_pkg::FN_EQ:  res_w.truth = eq_w;
      rau_pkg::FN_NE:  res_w.truth = unordered || lt_w || gt_w;
      default: begin
        // unused codes give an all-zero result
        res_w.res_num  = '0;
        res_w.res_den  = '0;
        res_w.den_zero = 1'b0;
      end
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // strobe lasts exactly one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // a transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("input transfer did not start the sequencer");

  // gcd completion is only seen while the sequencer waits for it
  a_gcd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_done |-> state_r == ST_GCD)
    else $error("gcd finished outside its wait state");

  // divider completion only while waiting on the divider
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

  // a flagged zero denominator really is zero
  a_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.den_zero) |-> out_data.res_den == '0)
    else $error("den_zero set with a nonzero denominator");

endmodule
